### hw/rtl/hcp_pkg.sv
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher pair block.
package hcp_pkg;

	localparam int LetterW = 5;
	localparam int ProdW   = 2 * LetterW;
	localparam int SumW    = ProdW + 1;
	localparam int AddrW   = 3;
	localparam int DataW   = 5;

	localparam logic [LetterW-1:0] ALPHA = 5'd26 - 5'd0;

	// register indexes on the configuration port
	localparam logic [AddrW-1:0] REG_KEY_R0C0  = 3'd0;
	localparam logic [AddrW-1:0] REG_KEY_R0C1  = 3'd1;
	localparam logic [AddrW-1:0] REG_KEY_R1C0  = 3'd2;
	localparam logic [AddrW-1:0] REG_KEY_R1C1  = 3'd3;
	localparam logic [AddrW-1:0] REG_DIRECTION = 3'd4;

	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	typedef logic [LetterW-1:0] letter_t;
	typedef logic [ProdW-1:0]   prod_t;

	typedef struct packed {
		letter_t m00;
		letter_t m01;
		letter_t m10;
		letter_t m11;
	} matrix_t;

	// load enables of the key stages, driven from the top level handshake chain
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} key_en_t;

	// 5-bit value into 0..25
	function automatic letter_t red26(input letter_t v);
		letter_t r;
		r = (v >= ALPHA) ? letter_t'(v - ALPHA) : v;
		return r;
	endfunction

	// (26 - v) mod 26 for v in 0..25
	function automatic letter_t neg26(input letter_t v);
		letter_t r;
		r = (v == '0) ? '0 : letter_t'(ALPHA - v);
		return r;
	endfunction

	// x mod 26 for x up to 1250: reciprocal 39/1024 underestimates the
	// quotient by at most one, so a single compare and subtract corrects it
	function automatic letter_t mod26(input logic [SumW-1:0] x);
		logic [SumW+5:0] prod;
		logic [6:0]      q;
		logic [SumW-1:0] r;
		letter_t         res;
		prod = {6'd0, x} * 17'd39;
		q    = prod[SumW+5:10];
		r    = x - (SumW'(q) * SumW'(26));
		res  = (r >= SumW'(26)) ? letter_t'(r - SumW'(26)) : letter_t'(r);
		return res;
	endfunction

	// inverse mod 26; zero where none exists
	function automatic letter_t inv26(input letter_t d);
		letter_t r;
		case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/hill_cipher_pair.sv
// Top level of the 2x2 Hill cipher pair block: config registers, letter pipeline, output.
// Takes one letter pair per cycle while in_ready is high and returns one transformed pair
// per pair, in order. The pipeline has seven stages: key reduction, determinant,
// inverse lookup, adjugate products, matrix reduction mod 26, letter products and the
// final mod-26 sum. Each stage holds its item under backpressure and frees as soon as
// the next one moves, so bubbles close up. With direction set and a key whose
// determinant is not a unit mod 26, the results carry key_invalid and zero letters.
// Key registers may only be written with the pipeline empty.
module hill_cipher_pair (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hcp_pkg::AddrW-1:0]      cfg_addr,
	input  logic [hcp_pkg::DataW-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [4:0]                     letter_first,
	input  logic [4:0]                     letter_second,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [4:0]                     out_first,
	output logic [4:0]                     out_second,
	output logic                           key_invalid
);

	hcp_pkg::letter_t key_r0c0_q, key_r0c1_q, key_r1c0_q, key_r1c1_q;
	logic             direction_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	hcp_pkg::letter_t p0_s1, p1_s1, p0_s2, p1_s2, p0_s3, p1_s3;
	hcp_pkg::letter_t p0_s4, p1_s4, p0_s5, p1_s5;
	hcp_pkg::prod_t   q00_s6, q01_s6, q10_s6, q11_s6;
	logic             invalid_s6;

	hcp_pkg::key_en_t key_en;
	hcp_pkg::matrix_t mat_s5;
	logic             invalid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_r0c0_q  <= 5'd3;
			key_r0c1_q  <= 5'd3;
			key_r1c0_q  <= 5'd2;
			key_r1c1_q  <= 5'd5;
			direction_q <= hcp_pkg::DIR_ENCRYPT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				hcp_pkg::REG_KEY_R0C0:  key_r0c0_q  <= cfg_wdata;
				hcp_pkg::REG_KEY_R0C1:  key_r0c1_q  <= cfg_wdata;
				hcp_pkg::REG_KEY_R1C0:  key_r1c0_q  <= cfg_wdata;
				hcp_pkg::REG_KEY_R1C1:  key_r1c1_q  <= cfg_wdata;
				hcp_pkg::REG_DIRECTION: direction_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// a stage loads when empty or when its item moves on
	assign en7 = !v_s7 || out_ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	assign key_en = '{s1: en1, s2: en2, s3: en3, s4: en4, s5: en5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	hcp_keymat u_keymat (
		.clk        (clk),
		.en         (key_en),
		.key_r0c0   (key_r0c0_q),
		.key_r0c1   (key_r0c1_q),
		.key_r1c0   (key_r1c0_q),
		.key_r1c1   (key_r1c1_q),
		.direction  (direction_q),
		.mat_s5     (mat_s5),
		.invalid_s5 (invalid_s5)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			p0_s1 <= hcp_pkg::red26(letter_first);
			p1_s1 <= hcp_pkg::red26(letter_second);
		end
		if (en2) begin
			p0_s2 <= p0_s1;
			p1_s2 <= p1_s1;
		end
		if (en3) begin
			p0_s3 <= p0_s2;
			p1_s3 <= p1_s2;
		end
		if (en4) begin
			p0_s4 <= p0_s3;
			p1_s4 <= p1_s3;
		end
		if (en5) begin
			p0_s5 <= p0_s4;
			p1_s5 <= p1_s4;
		end
		if (en6) begin
			q00_s6     <= hcp_pkg::prod_t'(p0_s5) * hcp_pkg::prod_t'(mat_s5.m00);
			q10_s6     <= hcp_pkg::prod_t'(p1_s5) * hcp_pkg::prod_t'(mat_s5.m10);
			q01_s6     <= hcp_pkg::prod_t'(p0_s5) * hcp_pkg::prod_t'(mat_s5.m01);
			q11_s6     <= hcp_pkg::prod_t'(p1_s5) * hcp_pkg::prod_t'(mat_s5.m11);
			invalid_s6 <= invalid_s5;
		end
		if (en7) begin
			out_first   <= hcp_pkg::mod26({1'b0, q00_s6} + {1'b0, q10_s6});
			out_second  <= hcp_pkg::mod26({1'b0, q01_s6} + {1'b0, q11_s6});
			key_invalid <= invalid_s6;
		end
	end

	assign out_valid = v_s7;

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_invalid |-> out_first == '0 && out_second == '0)
		else $error("invalid key item with non-zero letters");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_first < 5'd26 && out_second < 5'd26)
		else $error("output letter out of range");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off with free output");

	a_invalid_only_decrypt: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && invalid_s5 |-> mat_s5 == '0)
		else $error("non-zero matrix for key without inverse");
`endif

endmodule

### hw/rtl/hcp_keymat.sv
// Five-stage key path: reduces the key, inverts it mod 26 when decrypting.
module hcp_keymat (
	input  logic                 clk,
	input  hcp_pkg::key_en_t     en,
	input  hcp_pkg::letter_t     key_r0c0,
	input  hcp_pkg::letter_t     key_r0c1,
	input  hcp_pkg::letter_t     key_r1c0,
	input  hcp_pkg::letter_t     key_r1c1,
	input  logic                 direction,
	output hcp_pkg::matrix_t     mat_s5,
	output logic                 invalid_s5
);

	hcp_pkg::letter_t a_s1, b_s1, c_s1, d_s1, nb_s1, nc_s1;
	hcp_pkg::prod_t   ad_s1, bc_s1;
	logic             dir_s1;

	hcp_pkg::letter_t a_s2, b_s2, c_s2, d_s2, nb_s2, nc_s2, adr_s2, bcr_s2;
	logic             dir_s2;

	hcp_pkg::letter_t a_s3, b_s3, c_s3, d_s3, nb_s3, nc_s3, di_s3;
	logic             dir_s3;

	hcp_pkg::letter_t a_s4, b_s4, c_s4, d_s4;
	hcp_pkg::prod_t   p00_s4, p01_s4, p10_s4, p11_s4;
	logic             dir_s4, invalid_s4;

	hcp_pkg::letter_t a_r, b_r, c_r, d_r;
	logic [5:0]       det_raw;
	hcp_pkg::letter_t det;

	assign a_r = hcp_pkg::red26(key_r0c0);
	assign b_r = hcp_pkg::red26(key_r0c1);
	assign c_r = hcp_pkg::red26(key_r1c0);
	assign d_r = hcp_pkg::red26(key_r1c1);

	// adr + 26 - bcr stays below 52
	assign det_raw = 6'(adr_s2) + 6'd26 - 6'(bcr_s2);
	assign det = (det_raw >= 6'd26) ? hcp_pkg::letter_t'(det_raw - 6'd26)
		: hcp_pkg::letter_t'(det_raw);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			a_s1   <= a_r;
			b_s1   <= b_r;
			c_s1   <= c_r;
			d_s1   <= d_r;
			nb_s1  <= hcp_pkg::neg26(b_r);
			nc_s1  <= hcp_pkg::neg26(c_r);
			ad_s1  <= hcp_pkg::prod_t'(a_r) * hcp_pkg::prod_t'(d_r);
			bc_s1  <= hcp_pkg::prod_t'(b_r) * hcp_pkg::prod_t'(c_r);
			dir_s1 <= direction;
		end
		if (en.s2) begin
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
			d_s2   <= d_s1;
			nb_s2  <= nb_s1;
			nc_s2  <= nc_s1;
			adr_s2 <= hcp_pkg::mod26({1'b0, ad_s1});
			bcr_s2 <= hcp_pkg::mod26({1'b0, bc_s1});
			dir_s2 <= dir_s1;
		end
		if (en.s3) begin
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			c_s3   <= c_s2;
			d_s3   <= d_s2;
			nb_s3  <= nb_s2;
			nc_s3  <= nc_s2;
			di_s3  <= hcp_pkg::inv26(det);
			dir_s3 <= dir_s2;
		end
		if (en.s4) begin
			a_s4       <= a_s3;
			b_s4       <= b_s3;
			c_s4       <= c_s3;
			d_s4       <= d_s3;
			p00_s4     <= hcp_pkg::prod_t'(di_s3) * hcp_pkg::prod_t'(d_s3);
			p01_s4     <= hcp_pkg::prod_t'(di_s3) * hcp_pkg::prod_t'(nb_s3);
			p10_s4     <= hcp_pkg::prod_t'(di_s3) * hcp_pkg::prod_t'(nc_s3);
			p11_s4     <= hcp_pkg::prod_t'(di_s3) * hcp_pkg::prod_t'(a_s3);
			dir_s4     <= dir_s3;
			invalid_s4 <= (dir_s3 == hcp_pkg::DIR_DECRYPT) && (di_s3 == '0);
		end
		// when decrypting with no inverse all products are zero, so the matrix clears itself
		if (en.s5) begin
			if (dir_s4 == hcp_pkg::DIR_DECRYPT) begin
				mat_s5.m00 <= hcp_pkg::mod26({1'b0, p00_s4});
				mat_s5.m01 <= hcp_pkg::mod26({1'b0, p01_s4});
				mat_s5.m10 <= hcp_pkg::mod26({1'b0, p10_s4});
				mat_s5.m11 <= hcp_pkg::mod26({1'b0, p11_s4});
			end else begin
				mat_s5.m00 <= a_s4;
				mat_s5.m01 <= b_s4;
				mat_s5.m10 <= c_s4;
				mat_s5.m11 <= d_s4;
			end
			invalid_s5 <= invalid_s4;
		end
	end

endmodule

### bench/hill_cipher_pair_test.sv
// Self-checking bench for the 2x2 Hill cipher pair block: keys, directions, letters, idling.
`timescale 1ns / 100ps

module hill_cipher_pair_test;

	localparam int LETTERS     = 26;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		hcp_pkg::letter_t first;
		hcp_pkg::letter_t second;
		logic             bad_key;
	} cipher_out_t;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          cfg_we        = 1'b0;
	logic [hcp_pkg::AddrW-1:0]     cfg_addr      = '0;
	logic [hcp_pkg::DataW-1:0]     cfg_wdata     = '0;
	logic                          in_valid      = 1'b0;
	logic                          in_ready;
	logic [4:0]                    letter_first  = '0;
	logic [4:0]                    letter_second = '0;
	logic                          out_valid;
	logic                          out_ready     = 1'b0;
	logic [4:0]                    out_first;
	logic [4:0]                    out_second;
	logic                          key_invalid;

	// shadow copy of the key registers
	hcp_pkg::letter_t key_k00 = 5'd3;
	hcp_pkg::letter_t key_k01 = 5'd3;
	hcp_pkg::letter_t key_k10 = 5'd2;
	hcp_pkg::letter_t key_k11 = 5'd5;
	logic             key_dir = hcp_pkg::DIR_ENCRYPT;

	cipher_out_t expected_pairs[$];
	int          mismatches    = 0;
	int          cycle_count   = 0;
	int          send_idle_pct = 30;
	int          recv_idle_pct = 69;

	hill_cipher_pair u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.letter_first  (letter_first),
		.letter_second (letter_second),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_first     (out_first),
		.out_second    (out_second),
		.key_invalid   (key_invalid)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL hill_cipher_pair");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// row vector times key (or its inverse mod 26 when decrypting)
	function automatic cipher_out_t hill_transform(hcp_pkg::letter_t l0,
			hcp_pkg::letter_t l1);
		int          p0, p1, a, b, c, d, det, inv;
		int          m00, m01, m10, m11;
		cipher_out_t r;
		r   = '0;
		p0  = int'(l0) % LETTERS;
		p1  = int'(l1) % LETTERS;
		a   = int'(key_k00) % LETTERS;
		b   = int'(key_k01) % LETTERS;
		c   = int'(key_k10) % LETTERS;
		d   = int'(key_k11) % LETTERS;
		m00 = a;
		m01 = b;
		m10 = c;
		m11 = d;
		if (key_dir == hcp_pkg::DIR_DECRYPT) begin
			det = ((a * d - b * c) % LETTERS + LETTERS) % LETTERS;
			inv = 0;
			for (int x = 1; x < LETTERS; x++) begin
				if (inv == 0 && (det * x) % LETTERS == 1)
					inv = x;
			end
			if (inv == 0) begin
				r.bad_key = 1'b1;
				return r;
			end
			m00 = (inv * d) % LETTERS;
			m01 = (inv * ((LETTERS - b) % LETTERS)) % LETTERS;
			m10 = (inv * ((LETTERS - c) % LETTERS)) % LETTERS;
			m11 = (inv * a) % LETTERS;
		end
		r.first  = hcp_pkg::letter_t'((p0 * m00 + p1 * m10) % LETTERS);
		r.second = hcp_pkg::letter_t'((p0 * m01 + p1 * m11) % LETTERS);
		return r;
	endfunction

	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pairs.size() == 0) begin
				$error("result with no item outstanding: %0d %0d %0d",
					out_first, out_second, key_invalid);
				mismatches++;
			end else begin
				want = expected_pairs.pop_front();
				if (out_first !== want.first) begin
					$error("out_first: expected %0d, actual %0d", want.first, out_first);
					mismatches++;
				end
				if (out_second !== want.second) begin
					$error("out_second: expected %0d, actual %0d", want.second, out_second);
					mismatches++;
				end
				if (key_invalid !== want.bad_key) begin
					$error("key_invalid: expected %0d, actual %0d", want.bad_key, key_invalid);
					mismatches++;
				end
			end
		end
	end

	function automatic hcp_pkg::letter_t pick_letter();
		return ($urandom_range(4) == 0) ? hcp_pkg::letter_t'($urandom_range(31))
			: hcp_pkg::letter_t'($urandom_range(25));
	endfunction

	function automatic hcp_pkg::letter_t pick_key();
		case ($urandom_range(9))
			0: return 5'd0;
			1: return 5'd25;
			2: return 5'd31;
			3: return hcp_pkg::letter_t'($urandom_range(31, 26));
			default: return hcp_pkg::letter_t'($urandom_range(25));
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_pair(hcp_pkg::letter_t l0, hcp_pkg::letter_t l1);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid      <= 1'b1;
		letter_first  <= l0;
		letter_second <= l1;
		do
			@(posedge clk);
		while (!in_ready);
		expected_pairs.push_back(hill_transform(l0, l1));
	endtask

	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
	endtask

	// leaves cfg_we high; the caller drops it after its last write
	task automatic write_reg(logic [hcp_pkg::AddrW-1:0] idx,
			logic [hcp_pkg::DataW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			hcp_pkg::REG_KEY_R0C0:  key_k00 = val;
			hcp_pkg::REG_KEY_R0C1:  key_k01 = val;
			hcp_pkg::REG_KEY_R1C0:  key_k10 = val;
			hcp_pkg::REG_KEY_R1C1:  key_k11 = val;
			hcp_pkg::REG_DIRECTION: key_dir = val[0];
			default: ;
		endcase
	endtask

	task automatic set_key(hcp_pkg::letter_t a, hcp_pkg::letter_t b, hcp_pkg::letter_t c,
			hcp_pkg::letter_t d, logic dir, bit with_stray);
		settle_pipeline();
		write_reg(hcp_pkg::REG_KEY_R0C0, a);
		write_reg(hcp_pkg::REG_KEY_R0C1, b);
		write_reg(hcp_pkg::REG_KEY_R1C0, c);
		write_reg(hcp_pkg::REG_KEY_R1C1, d);
		write_reg(hcp_pkg::REG_DIRECTION, hcp_pkg::DataW'(dir));
		if (with_stray)
			write_reg(hcp_pkg::AddrW'($urandom_range((1 << hcp_pkg::AddrW) - 1,
				int'(hcp_pkg::REG_DIRECTION) + 1)), hcp_pkg::DataW'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_key();
		send_pair(5'd0, 5'd0);
		send_pair(5'd25, 5'd25);
		send_pair(5'd31, 5'd31);
		send_pair(5'd26, 5'd27);
		send_pair(5'd0, 5'd25);
		send_pair(5'd25, 5'd0);
		// reset key has determinant 9, so decryption works with it
		settle_pipeline();
		write_reg(hcp_pkg::REG_DIRECTION, hcp_pkg::DataW'(hcp_pkg::DIR_DECRYPT));
		cfg_we <= 1'b0;
		send_pair(5'd25, 5'd31);
		send_pair(5'd7, 5'd19);
	endtask

	task automatic test_edge_keys();
		set_key(5'd0, 5'd0, 5'd0, 5'd0, hcp_pkg::DIR_ENCRYPT, 1'b0);
		send_pair(5'd25, 5'd31);
		set_key(5'd31, 5'd31, 5'd31, 5'd31, hcp_pkg::DIR_ENCRYPT, 1'b0);
		send_pair(5'd25, 5'd31);
		send_pair(5'd1, 5'd2);
		// determinant of one, and of 25 (its own inverse)
		set_key(5'd1, 5'd0, 5'd0, 5'd1, hcp_pkg::DIR_DECRYPT, 1'b0);
		send_pair(5'd25, 5'd31);
		set_key(5'd25, 5'd0, 5'd0, 5'd1, hcp_pkg::DIR_DECRYPT, 1'b0);
		send_pair(5'd13, 5'd30);
		// negative determinant
		set_key(5'd1, 5'd3, 5'd2, 5'd1, hcp_pkg::DIR_DECRYPT, 1'b0);
		send_pair(5'd25, 5'd31);
		send_pair(5'd1, 5'd2);
		// key entries above 25
		set_key(5'd27, 5'd3, 5'd28, 5'd31, hcp_pkg::DIR_DECRYPT, 1'b0);
		send_pair(5'd11, 5'd4);
		// determinant shares a factor with 26
		set_key(5'd2, 5'd0, 5'd0, 5'd1, hcp_pkg::DIR_DECRYPT, 1'b0);
		send_pair(5'd25, 5'd31);
		set_key(5'd13, 5'd0, 5'd0, 5'd1, hcp_pkg::DIR_DECRYPT, 1'b0);
		send_pair(5'd1, 5'd2);
		set_key(5'd13, 5'd0, 5'd0, 5'd1, hcp_pkg::DIR_ENCRYPT, 1'b0);
		send_pair(5'd1, 5'd2);
	endtask

	task automatic test_stray_index();
		set_key(5'd3, 5'd7, 5'd4, 5'd9, hcp_pkg::DIR_DECRYPT, 1'b0);
		@(posedge clk);
		for (int i = int'(hcp_pkg::REG_DIRECTION) + 1; i < (1 << hcp_pkg::AddrW); i++)
			write_reg(hcp_pkg::AddrW'(i),
				(i % 2 == 0) ? hcp_pkg::DataW'(31) : hcp_pkg::DataW'(0));
		cfg_we <= 1'b0;
		send_pair(5'd17, 5'd22);
		send_pair(5'd31, 5'd0);
	endtask

	task automatic test_random_traffic(int items, int send_pct, int recv_pct);
		int until_rekey;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		until_rekey   = 0;
		for (int i = 0; i < items; i++) begin
			if (until_rekey == 0) begin
				set_key(pick_key(), pick_key(), pick_key(), pick_key(),
					logic'($urandom_range(1)), $urandom_range(3) == 0);
				until_rekey = $urandom_range(60, 20);
			end
			until_rekey--;
			send_pair(pick_letter(), pick_letter());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_edge_keys();
		test_stray_index();
		test_random_traffic(170, 30, 69);
		test_random_traffic(170, 69, 30);
		test_random_traffic(170, 0, 0);
		settle_pipeline();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_pairs.size() == 0)
			$display("PASS hill_cipher_pair");
		else
			$display("FAIL hill_cipher_pair");
		$finish;
	end

endmodule
